>>> src/bsmm_pkg.sv
// Shared types, sizes and command/status codes for the bounded stack unit.
package bsmm_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int WORD_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    typedef logic [2:0]               t_cmd;
    typedef logic [1:0]               t_status;
    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [ADDR_W-1:0]        t_addr;

    localparam t_cmd CMD_PUSH = 3'd0;
    localparam t_cmd CMD_POP  = 3'd1;
    localparam t_cmd CMD_MAX  = 3'd2;
    localparam t_cmd CMD_MIN  = 3'd3;
    localparam t_cmd CMD_DUMP = 3'd4;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    typedef struct packed {
        logic  we;
        t_addr addr;
        t_word data;
    } t_wr;

    typedef struct packed {
        logic en;
        logic load;
        logic is_max;
    } t_cmp_ctl;

endpackage

>>> src/bsmm_if.sv
// Request and response channel interfaces of the bounded stack unit.
interface bsmm_req_if;
    import bsmm_pkg::*;
    logic  valid;
    logic  ready;
    t_cmd  command;
    t_word push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface bsmm_rsp_if;
    import bsmm_pkg::*;
    logic    valid;
    logic    ready;
    t_status status;
    t_word   result_value;
    logic    last_of_run;

    modport source (output valid, output status, output result_value, output last_of_run,
                    input ready);
    modport sink   (input valid, input status, input result_value, input last_of_run,
                    output ready);
endinterface

>>> src/bounded_stack_with_min_max_query_unit.sv
// Top level: bounded stack with max/min scan and dump, command sequencer.
//
// Usage: commands enter on i_req (valid/ready, payload command and push_value);
// results leave on o_rsp (status, result_value, last_of_run). A request is
// taken only while the sequencer is idle, one request at a time.
// Push, pop and any command on an empty stack: one result, loaded into the
// output register from the emit state.
// Max/min: the scan reads one stored word per cycle through the shared
// compare unit; the result is then loaded into the output register from the
// emit state.
// Dump (also any unused code on a non-empty stack): one result per stored
// word, bottom first, each word in a memory read state, then an output load
// state; the final one has last_of_run set.
// Scan and dump time grow with the stored word count, as set by the single
// memory read port and compare unit.
// The next request is taken as soon as the last result sits in the output
// register, even if the receiver has not yet taken it.
// When the receiver stalls, the output register holds its result and the
// sequencer waits; nothing is dropped.
// Reset empties the stack; stored words are not cleared and are never read
// before they are written.
module bounded_stack_with_min_max_query_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsmm_req_if.sink   i_req,
    bsmm_rsp_if.source o_rsp
);
    import bsmm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DRD  = 3'd2;
    localparam logic [2:0] S_DOUT = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] r_state, n_state;
    t_cnt       r_count, n_count;
    t_cnt       r_iss, n_iss;
    logic       r_is_max, n_is_max;
    logic       r_dv, n_dv;
    logic       r_dfirst, n_dfirst;
    logic       r_dlast, n_dlast;
    t_status    r_pend_st, n_pend_st;
    logic       r_pend_best, n_pend_best;
    logic       r_out_valid, n_out_valid;
    t_status    r_out_st, n_out_st;
    t_word      r_out_val, n_out_val;
    logic       r_out_last, n_out_last;

    t_wr        w_wr;
    t_cmp_ctl   w_cmp;
    t_word      w_rdata;
    t_word      w_best;
    logic       w_acc;
    logic       w_free;
    logic       w_iss_last;

    bsmm_store u_store (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (r_iss[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    bsmm_cmp u_cmp (
        .i_clk  (i_clk),
        .i_ctl  (w_cmp),
        .i_data (w_rdata),
        .o_best (w_best)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && (r_state == S_IDLE);
    assign w_free      = !r_out_valid || o_rsp.ready;
    assign w_iss_last  = (r_iss + t_cnt'(1)) == r_count;

    assign w_cmp.en     = r_dv;
    assign w_cmp.load   = r_dfirst;
    assign w_cmp.is_max = r_is_max;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_iss       = r_iss;
        n_is_max    = r_is_max;
        n_dv        = 1'b0;
        n_dfirst    = r_dfirst;
        n_dlast     = r_dlast;
        n_pend_st   = r_pend_st;
        n_pend_best = r_pend_best;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_st    = r_out_st;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;
        w_wr.we     = 1'b0;
        w_wr.addr   = r_count[ADDR_W-1:0];
        w_wr.data   = i_req.push_value;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_pend_best = 1'b0;
                    n_iss       = '0;
                    priority if (i_req.command == CMD_PUSH) begin
                        n_state = S_EMIT;
                        if (r_count == t_cnt'(STACK_DEPTH)) begin
                            n_pend_st = ST_FULL;
                        end else begin
                            w_wr.we   = 1'b1;
                            n_count   = r_count + t_cnt'(1);
                            n_pend_st = ST_OK;
                        end
                    end else if (r_count == '0) begin
                        n_state   = S_EMIT;
                        n_pend_st = ST_EMPTY;
                    end else if (i_req.command == CMD_POP) begin
                        n_state   = S_EMIT;
                        n_count   = r_count - t_cnt'(1);
                        n_pend_st = ST_OK;
                    end else if (i_req.command == CMD_MAX || i_req.command == CMD_MIN) begin
                        n_state  = S_SCAN;
                        n_is_max = (i_req.command == CMD_MAX);
                    end else begin
                        n_state = S_DRD;
                    end
                end
            end
            S_SCAN: begin
                if (r_iss != r_count) begin
                    n_dv     = 1'b1;
                    n_dfirst = (r_iss == '0);
                    n_dlast  = w_iss_last;
                    n_iss    = r_iss + t_cnt'(1);
                end
                if (r_dv && r_dlast) begin
                    n_state     = S_EMIT;
                    n_pend_st   = ST_OK;
                    n_pend_best = 1'b1;
                end
            end
            S_DRD: begin
                n_state = S_DOUT;
            end
            S_DOUT: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_st    = ST_OK;
                    n_out_val   = w_rdata;
                    n_out_last  = w_iss_last;
                    if (w_iss_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_iss   = r_iss + t_cnt'(1);
                        n_state = S_DRD;
                    end
                end
            end
            S_EMIT: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_pend_st;
                    n_out_val   = r_pend_best ? w_best : '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iss       <= n_iss;
        r_is_max    <= n_is_max;
        r_dfirst    <= n_dfirst;
        r_dlast     <= n_dlast;
        r_pend_st   <= n_pend_st;
        r_pend_best <= n_pend_best;
        r_out_st    <= n_out_st;
        r_out_val   <= n_out_val;
        r_out_last  <= n_out_last;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_st;
    assign o_rsp.result_value = r_out_val;
    assign o_rsp.last_of_run  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(STACK_DEPTH))
        else $error("entry count above depth");

    a_scan_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == S_SCAN))
        else $error("compare unit active outside scan");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_req.command == CMD_PUSH && r_count == t_cnt'(STACK_DEPTH))
        |=> $stable(r_count))
        else $error("push on full stack changed count");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_DRD || r_state == S_DOUT) |-> (r_count != '0))
        else $error("scan on empty stack");

endmodule

>>> src/bsmm_store.sv
// Stack word memory: one write port, one registered read port.
module bsmm_store (
    input  logic           i_clk,
    input  bsmm_pkg::t_wr  i_wr,
    input  bsmm_pkg::t_addr i_raddr,
    output bsmm_pkg::t_word o_rdata
);
    import bsmm_pkg::*;

    t_word r_mem [STACK_DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bsmm_cmp.sv
// Shared signed compare unit holding the running maximum or minimum.
module bsmm_cmp (
    input  logic               i_clk,
    input  bsmm_pkg::t_cmp_ctl i_ctl,
    input  bsmm_pkg::t_word    i_data,
    output bsmm_pkg::t_word    o_best
);
    import bsmm_pkg::*;

    t_word r_best;
    logic  w_take;

    always_comb begin
        if (i_ctl.is_max) begin
            w_take = r_best < i_data;
        end else begin
            w_take = i_data < r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && (i_ctl.load || w_take)) begin
            r_best <= i_data;
        end
    end

    assign o_best = r_best;

endmodule

>>> tb/sv/bounded_stack_with_min_max_query_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for the bounded stack unit: directed and random command traffic checked against a stack predictor.
module bounded_stack_with_min_max_query_unit_tb;
    import bsmm_pkg::*;

    localparam t_cmd CMD_SPARE5  = 3'd5;
    localparam t_cmd CMD_SPARE6  = 3'd6;
    localparam t_cmd CMD_SPARE7  = 3'd7;
    localparam int   N_ITEMS     = 350;
    localparam int   CYCLE_LIMIT = 3_000_000;
    localparam int   LONG_HOLD   = 400;

    typedef struct {
        t_cmd  cmd;
        t_word value;
        bit    drain_first;
    } t_stack_req;

    typedef struct {
        t_status status;
        t_word   value;
        logic    last;
    } t_stack_reply;

    logic i_clk;
    logic i_rst_n;

    bsmm_req_if req_ch ();
    bsmm_rsp_if rsp_ch ();

    bounded_stack_with_min_max_query_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    t_stack_req   pending_reqs[$];
    t_stack_reply awaited_replies[$];
    t_stack_req   on_bus;

    t_word model_store[STACK_DEPTH];
    int    model_depth;
    int    gen_depth;
    bit    drain_next;

    int n_accepted, n_results, n_mismatch, n_full, n_empty, n_dumps, n_scans;
    int cycle_count;
    int send_gap, send_calm, recv_stall, recv_calm, hold_left;
    bit long_hold_done;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int idle_len(ref int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            4, 5: return $signed($urandom_range(0, 200)) - 32'sd100;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_req(input t_cmd cmd, input t_word value);
        t_stack_req r;
        r.cmd = cmd;
        r.value = value;
        r.drain_first = drain_next;
        drain_next = 1'b0;
        pending_reqs.push_back(r);
        if (cmd == CMD_PUSH && gen_depth < STACK_DEPTH) gen_depth++;
        else if (cmd == CMD_POP && gen_depth > 0) gen_depth--;
    endtask

    task automatic queue_reply(input t_status st, input t_word value, input logic last);
        t_stack_reply r;
        r.status = st;
        r.value = value;
        r.last = last;
        awaited_replies.push_back(r);
    endtask

    // stack behavior for one accepted request
    task automatic stack_apply(input t_cmd cmd, input t_word value);
        t_word best;
        if (cmd == CMD_PUSH) begin
            if (model_depth >= STACK_DEPTH) begin
                queue_reply(ST_FULL, '0, 1'b1);
                n_full++;
            end else begin
                model_store[model_depth] = value;
                model_depth++;
                queue_reply(ST_OK, '0, 1'b1);
            end
        end else if (model_depth == 0) begin
            queue_reply(ST_EMPTY, '0, 1'b1);
            n_empty++;
        end else if (cmd == CMD_POP) begin
            model_depth--;
            queue_reply(ST_OK, '0, 1'b1);
        end else if (cmd == CMD_MAX || cmd == CMD_MIN) begin
            best = model_store[0];
            for (int i = 1; i < model_depth; i++) begin
                if (cmd == CMD_MAX ? (model_store[i] > best) : (model_store[i] < best))
                    best = model_store[i];
            end
            queue_reply(ST_OK, best, 1'b1);
            n_scans++;
        end else begin
            for (int i = 0; i < model_depth; i++)
                queue_reply(ST_OK, model_store[i], (i == model_depth - 1));
            n_dumps++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.command <= CMD_PUSH;
            req_ch.push_value <= '0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                stack_apply(on_bus.cmd, on_bus.value);
                n_accepted++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() > 0 &&
                             (!pending_reqs[0].drain_first || awaited_replies.size() == 0)) begin
                    on_bus = pending_reqs.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.command <= on_bus.cmd;
                    req_ch.push_value <= on_bus.value;
                    send_gap = idle_len(send_calm);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        t_stack_reply want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                n_results++;
                if (awaited_replies.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result: status %0d value %0d last %0b",
                                 rsp_ch.status, rsp_ch.result_value, rsp_ch.last_of_run);
                end else begin
                    want = awaited_replies.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.result_value !== want.value ||
                        rsp_ch.last_of_run !== want.last) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display({"result %0d: expected st %0d val %0d last %0b,",
                                      " got st %0d val %0d last %0b"},
                                     n_results, want.status, want.value, want.last,
                                     rsp_ch.status, rsp_ch.result_value, rsp_ch.last_of_run);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!long_hold_done && n_accepted >= 150) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                recv_stall = idle_len(recv_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_replies.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int seg, target, fills;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_PUSH;
        req_ch.push_value = '0;
        rsp_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        model_depth = 0;
        gen_depth = 0;
        fills = 0;

        // empty store, every command but push
        add_req(CMD_MAX, '0);
        add_req(CMD_MIN, '0);
        add_req(CMD_POP, '0);
        add_req(CMD_DUMP, '0);
        add_req(CMD_SPARE5, '0);
        add_req(CMD_SPARE6, '0);
        add_req(CMD_SPARE7, '0);
        // stored zero must count in both scans
        add_req(CMD_PUSH, '0);
        add_req(CMD_MAX, -32'sd1);
        add_req(CMD_MIN, 32'sh7fff_ffff);
        add_req(CMD_PUSH, 32'sh8000_0000);
        add_req(CMD_PUSH, 32'sh7fff_ffff);
        add_req(CMD_PUSH, -32'sd1);
        add_req(CMD_MAX, '0);
        add_req(CMD_MIN, '0);
        add_req(CMD_DUMP, '0);
        add_req(CMD_SPARE7, '0);
        add_req(CMD_POP, '0);
        add_req(CMD_MIN, '0);
        add_req(CMD_POP, '0);
        add_req(CMD_POP, '0);
        add_req(CMD_POP, '0);
        add_req(CMD_POP, '0);
        drain_next = 1'b1;

        while (pending_reqs.size() < N_ITEMS) begin
            seg = $urandom_range(0, 99);
            if (fills < 2 && pending_reqs.size() < N_ITEMS - 150 &&
                (seg < 5 || (fills == 0 && pending_reqs.size() > 150))) begin
                // fill to capacity, overflow, query and dump, drain to empty, then pop and max on empty
                fills++;
                while (gen_depth < STACK_DEPTH) add_req(CMD_PUSH, rand_word());
                repeat ($urandom_range(1, 3)) add_req(CMD_PUSH, rand_word());
                add_req(CMD_MAX, rand_word());
                add_req(CMD_MIN, rand_word());
                add_req(CMD_DUMP, rand_word());
                while (gen_depth > 0) add_req(CMD_POP, rand_word());
                add_req(CMD_POP, rand_word());
                add_req(CMD_MAX, rand_word());
            end else if (seg < 12) begin
                repeat ($urandom_range(2, 6)) add_req(t_cmd'($urandom_range(0, 7)), rand_word());
            end else begin
                target = ($urandom_range(0, 9) == 0) ? $urandom_range(20, STACK_DEPTH)
                                                     : $urandom_range(0, 12);
                repeat ($urandom_range(8, 30)) begin
                    seg = $urandom_range(0, 99);
                    if (seg < 50) add_req(gen_depth < target ? CMD_PUSH : CMD_POP, rand_word());
                    else if (seg < 62) add_req(CMD_MAX, rand_word());
                    else if (seg < 74) add_req(CMD_MIN, rand_word());
                    else if (seg < 84) add_req(CMD_DUMP, rand_word());
                    else if (seg < 87) add_req(t_cmd'($urandom_range(5, 7)), rand_word());
                    else if (seg < 95) add_req(CMD_PUSH, rand_word());
                    else add_req(CMD_POP, rand_word());
                end
            end
            if ($urandom_range(0, 9) == 0) drain_next = 1'b1;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || req_ch.valid) @(posedge i_clk);
        while (awaited_replies.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("covered %0d requests and %0d results: %0d scans, %0d dumps,",
                 n_accepted, n_results, n_scans, n_dumps);
        $display("%0d full-store pushes, %0d empty-store replies, %0d mismatches",
                 n_full, n_empty, n_mismatch);
        if (n_mismatch == 0 && awaited_replies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
